@@ rtl/algq_pkg.sv @@
`timescale 1ns / 1ps
package algq_pkg;

    localparam int CFG_W       = 16;
    localparam int GEN_W       = 16;
    localparam int CNT_W       = CFG_W + 1;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] REG_BUS_THR   = 2'd0;
    localparam logic [1:0] REG_CUR_THR   = 2'd1;
    localparam logic [1:0] REG_HOLD      = 2'd2;
    localparam logic [1:0] REG_START_GEN = 2'd3;

    localparam logic [CFG_W-1:0] RST_BUS_THR   = 16'd0;
    localparam logic [CFG_W-1:0] RST_CUR_THR   = 16'd0;
    localparam logic [CFG_W-1:0] RST_HOLD      = 16'd2;
    localparam logic [GEN_W-1:0] RST_START_GEN = 16'd1;

    typedef struct packed {
        logic [CFG_W-1:0] bus_thr;
        logic [CFG_W-1:0] cur_thr;
        logic [CFG_W-1:0] hold;
        logic             gen_load;
        logic [GEN_W-1:0] gen_value;
    } t_cfg;

    typedef struct packed {
        logic cond;
        logic ovf;
    } t_cls;

endpackage

@@ rtl/algq_smp_if.sv @@
`timescale 1ns / 1ps
interface algq_smp_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] bus_sample;
    logic signed [SAMPLE_WIDTH-1:0] current_sample;
    logic                           overflow_flag;

    modport source (output valid, output bus_sample, output current_sample,
                    output overflow_flag, input ready);
    modport sink   (input valid, input bus_sample, input current_sample,
                    input overflow_flag, output ready);
endinterface

@@ rtl/algq_res_if.sv @@
`timescale 1ns / 1ps
interface algq_res_if;
    logic        valid;
    logic        ready;
    logic        record_enable;
    logic        session_start;
    logic        session_stop;
    logic [15:0] generation;
    logic        sample_status;

    modport source (output valid, output record_enable, output session_start,
                    output session_stop, output generation, output sample_status,
                    input ready);
    modport sink   (input valid, input record_enable, input session_start,
                    input session_stop, input generation, input sample_status,
                    output ready);
endinterface

@@ rtl/algq_cfg.sv @@
`timescale 1ns / 1ps
module algq_cfg
    import algq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [CFG_W-1:0] r_bus_thr;
    logic [CFG_W-1:0] r_cur_thr;
    logic [CFG_W-1:0] r_hold;
    logic [GEN_W-1:0] r_start_gen;
    logic             wr_en;
    logic [1:0]       reg_idx;
    logic [CFG_W-1:0] wr_val;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign wr_val  = pwdata[CFG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_thr   <= RST_BUS_THR;
            r_cur_thr   <= RST_CUR_THR;
            r_hold      <= RST_HOLD;
            r_start_gen <= RST_START_GEN;
        end else if (wr_en) begin
            case (reg_idx)
                REG_BUS_THR:   r_bus_thr   <= wr_val;
                REG_CUR_THR:   r_cur_thr   <= wr_val;
                REG_HOLD:      r_hold      <= wr_val;
                REG_START_GEN: r_start_gen <= wr_val;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BUS_THR:   prdata = APB_DATA_W'(r_bus_thr);
            REG_CUR_THR:   prdata = APB_DATA_W'(r_cur_thr);
            REG_HOLD:      prdata = APB_DATA_W'(r_hold);
            REG_START_GEN: prdata = APB_DATA_W'(r_start_gen);
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.bus_thr   = r_bus_thr;
        o_cfg.cur_thr   = r_cur_thr;
        o_cfg.hold      = r_hold;
        o_cfg.gen_load  = wr_en && (reg_idx == REG_START_GEN);
        o_cfg.gen_value = wr_val;
    end

endmodule

@@ rtl/algq_front.sv @@
`timescale 1ns / 1ps
module algq_front
    import algq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    algq_smp_if.sink   i_smp,
    output logic       o_valid,
    output t_cls       o_cls,
    input  logic       i_ready
);

    localparam int MAG_W = SAMPLE_WIDTH + 1;
    localparam int CMP_W = (MAG_W > CFG_W) ? MAG_W : CFG_W;

    logic             r_valid;
    logic             n_valid;
    t_cls             r_cls;
    logic [MAG_W-1:0] bus_mag;
    logic [MAG_W-1:0] cur_mag;
    logic             cond;
    logic             in_xfer;

    // Magnitude is one bit wider so that the most negative reading is exact.
    function automatic logic [MAG_W-1:0] magnitude(input logic [SAMPLE_WIDTH-1:0] x);
        logic [MAG_W-1:0] ext;
        ext = {x[SAMPLE_WIDTH-1], x};
        return x[SAMPLE_WIDTH-1] ? (~ext + 1'b1) : ext;
    endfunction

    assign bus_mag = magnitude(i_smp.bus_sample);
    assign cur_mag = magnitude(i_smp.current_sample);
    assign cond    = ((CMP_W'(bus_mag) >= CMP_W'(i_cfg.bus_thr)) &&
                      (CMP_W'(cur_mag) >= CMP_W'(i_cfg.cur_thr))) ||
                     i_smp.overflow_flag;

    assign i_smp.ready = !r_valid || i_ready;
    assign in_xfer     = i_smp.valid && i_smp.ready;

    always_comb begin
        n_valid = r_valid;
        if (in_xfer) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cls.cond <= cond;
            r_cls.ovf  <= i_smp.overflow_flag;
        end
    end

    assign o_valid = r_valid;
    assign o_cls   = r_cls;

endmodule

@@ rtl/algq_queue.sv @@
`timescale 1ns / 1ps
module algq_queue
    import algq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_cls              i_cls,
    output logic              o_ready,
    output logic              o_valid,
    output t_cls              o_cls,
    input  logic              i_ready,
    output logic [QCNT_W-1:0] o_level
);

    t_cls              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              push;
    logic              pop;

    assign o_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_cls   = r_mem[r_rd];
    assign o_level = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_cls;
        end
    end

endmodule

@@ rtl/algq_back.sv @@
`timescale 1ns / 1ps
module algq_back
    import algq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    input  t_cls        i_cls,
    output logic        o_ready,
    algq_res_if.source  o_res
);

    logic [CNT_W-1:0] r_met;
    logic [CNT_W-1:0] r_unmet;
    logic             r_active;
    logic [GEN_W-1:0] r_gen;
    logic [CNT_W-1:0] n_met;
    logic [CNT_W-1:0] n_unmet;
    logic             n_active;
    logic [GEN_W-1:0] n_gen;
    logic             n_start;
    logic             n_stop;
    logic [CNT_W-1:0] hold;
    logic [CNT_W-1:0] hold_p1;
    logic             pop;

    logic             r_out_valid;
    logic             r_rec;
    logic             r_start;
    logic             r_stop;
    logic [GEN_W-1:0] r_out_gen;
    logic             r_status;

    // A hold of zero behaves as a hold of one.
    assign hold    = (i_cfg.hold == '0) ? CNT_W'(1) : CNT_W'(i_cfg.hold);
    assign hold_p1 = hold + 1'b1;
    assign o_ready = !r_out_valid || o_res.ready;
    assign pop     = i_valid && o_ready;

    always_comb begin
        n_met    = r_met;
        n_unmet  = r_unmet;
        n_active = r_active;
        n_gen    = r_gen;
        n_start  = 1'b0;
        n_stop   = 1'b0;
        if (i_cls.cond) begin
            if (r_met < hold_p1) begin
                n_met = r_met + 1'b1;
            end
            n_unmet = '0;
        end else begin
            if (r_unmet < hold_p1) begin
                n_unmet = r_unmet + 1'b1;
            end
            n_met = '0;
        end
        if (!n_active && (n_met == hold)) begin
            n_active = 1'b1;
            n_met    = hold_p1;
            n_start  = 1'b1;
        end
        if (n_active && (n_unmet == hold)) begin
            n_active = 1'b0;
            n_unmet  = hold_p1;
            n_gen    = r_gen + 1'b1;
            n_stop   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_met       <= '0;
            r_unmet     <= '0;
            r_active    <= 1'b0;
            r_gen       <= RST_START_GEN;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.gen_load) begin
                r_gen <= i_cfg.gen_value;
            end else if (pop) begin
                r_gen <= n_gen;
            end
            if (pop) begin
                r_met    <= n_met;
                r_unmet  <= n_unmet;
                r_active <= n_active;
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_rec     <= n_active;
            r_start   <= n_start;
            r_stop    <= n_stop;
            r_out_gen <= n_gen;
            r_status  <= i_cls.ovf;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.record_enable = r_rec;
    assign o_res.session_start = r_start;
    assign o_res.session_stop  = r_stop;
    assign o_res.generation    = r_out_gen;
    assign o_res.sample_status = r_status;

endmodule

@@ rtl/activity_log_gate_qualifier_unit.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Transfer when           Payload
// i_smp     in         valid && ready          bus_sample, current_sample, overflow_flag
// o_res     out        valid && ready          record_enable, session_start, session_stop,
//                                              generation, sample_status
// APB       in/out     psel && penable && pwrite  bus/current threshold, hold, start generation
//
// One sample per cycle is sustained while o_res.ready holds; each sample passes through
// the classify register, two-entry queue and state update into the output register.
// The rate is set by the counter update in the back stage.
// Reset is synchronous and active low; it clears the pipeline and counters, loads the
// registers with their reset values and the generation with the reset start generation.
// A stalled output fills the queue and then the front register before i_smp.ready falls.
module activity_log_gate_qualifier_unit
    import algq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    algq_smp_if.sink              i_smp,
    algq_res_if.source            o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg              cfg;
    logic              f_valid;
    t_cls              f_cls;
    logic              q_in_ready;
    logic              q_valid;
    t_cls              q_cls;
    logic              b_ready;
    logic [QCNT_W-1:0] q_level;

    algq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    algq_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_smp   (i_smp),
        .o_valid (f_valid),
        .o_cls   (f_cls),
        .i_ready (q_in_ready)
    );

    algq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_cls   (f_cls),
        .o_ready (q_in_ready),
        .o_valid (q_valid),
        .o_cls   (q_cls),
        .i_ready (b_ready),
        .o_level (q_level)
    );

    algq_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (q_valid),
        .i_cls   (q_cls),
        .o_ready (b_ready),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    a_queue_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_level <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue level exceeds its depth");

    a_start_records: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.session_start) |-> o_res.record_enable)
        else $error("session start without record enable");

    a_stop_no_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.session_stop) |-> !o_res.record_enable)
        else $error("session stop with record enable");

    a_front_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (f_valid && !q_in_ready) |-> !i_smp.ready)
        else $error("input taken while the front register is blocked");
`endif

endmodule

@@ tb/activity_log_gate_qualifier_unit_tb.sv @@
`timescale 1ns / 1ps
module activity_log_gate_qualifier_unit_tb;
    import algq_pkg::*;

    localparam int SMP_W           = 16;
    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_OFF_CYCLES = 100;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_SAMPLES   = 197;
    localparam int DRAIN_CYCLES    = 8;

    localparam logic signed [SMP_W-1:0] S_MIN = 16'sh8000;
    localparam logic signed [SMP_W-1:0] S_MAX = 16'sh7FFF;

    typedef struct packed {
        logic signed [SMP_W-1:0] bus;
        logic signed [SMP_W-1:0] cur;
        logic                    ovf;
    } t_sample;

    typedef struct packed {
        logic             record_enable;
        logic             session_start;
        logic             session_stop;
        logic [GEN_W-1:0] generation;
        logic             sample_status;
    } t_gate_result;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_HOLD_OFF} t_rx_mode;

    // Holds its own copy of the registers and the hold counters, and queues the
    // gate decision expected for every sample that the block has taken.
    class t_gate_scoreboard;
        logic [CFG_W-1:0] thr_bus;
        logic [CFG_W-1:0] thr_cur;
        logic [CFG_W-1:0] hold_cfg;
        logic [GEN_W-1:0] gen_cfg;
        logic [CNT_W-1:0] met_run;
        logic [CNT_W-1:0] unmet_run;
        logic             logging;
        logic [GEN_W-1:0] gen_now;
        t_gate_result     expected_q[$];
        int errors, samples, results, opened, closed, wraps, overflows;

        function new();
            thr_bus   = RST_BUS_THR;
            thr_cur   = RST_CUR_THR;
            hold_cfg  = RST_HOLD;
            gen_cfg   = RST_START_GEN;
            met_run   = '0;
            unmet_run = '0;
            logging   = 1'b0;
            gen_now   = RST_START_GEN;
        endfunction

        function logic [SMP_W:0] magnitude(logic [SMP_W-1:0] raw);
            logic [SMP_W:0] wide;
            wide = {raw[SMP_W-1], raw};
            return wide[SMP_W] ? (~wide + 1'b1) : wide;
        endfunction

        function void write_register(logic [1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_BUS_THR: thr_bus = val;
                REG_CUR_THR: thr_cur = val;
                REG_HOLD:    hold_cfg = val;
                REG_START_GEN: begin
                    gen_cfg = val;
                    gen_now = val;
                end
                default: ;
            endcase
        endfunction

        function void note_sample(t_sample s);
            logic [CNT_W-1:0] hold_eff;
            logic [CNT_W-1:0] ceiling;
            logic             met;
            t_gate_result     want;
            hold_eff = (hold_cfg == '0) ? CNT_W'(1) : CNT_W'(hold_cfg);
            ceiling  = hold_eff + 1'b1;
            met = ((magnitude(s.bus) >= thr_bus) && (magnitude(s.cur) >= thr_cur)) || s.ovf;
            want = '0;
            samples++;
            if (s.ovf)
                overflows++;
            if (met) begin
                if (met_run < ceiling)
                    met_run = met_run + 1'b1;
                unmet_run = '0;
            end else begin
                if (unmet_run < ceiling)
                    unmet_run = unmet_run + 1'b1;
                met_run = '0;
            end
            if (!logging && met_run == hold_eff) begin
                logging = 1'b1;
                met_run = ceiling;
                want.session_start = 1'b1;
                opened++;
            end
            if (logging && unmet_run == hold_eff) begin
                logging   = 1'b0;
                unmet_run = ceiling;
                gen_now   = gen_now + 1'b1;
                if (gen_now == '0)
                    wraps++;
                want.session_stop = 1'b1;
                closed++;
            end
            want.record_enable = logging;
            want.generation    = gen_now;
            want.sample_status = s.ovf;
            expected_q.push_back(want);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(string msg);
            $display("ERROR: result %0d: %s", results, msg);
            errors++;
        endtask

        task check_result(t_gate_result got);
            t_gate_result want;
            results++;
            if (expected_q.size() == 0) begin
                report_mismatch("transfer with no sample outstanding");
                return;
            end
            want = expected_q.pop_front();
            if (got.record_enable !== want.record_enable)
                report_mismatch($sformatf("record_enable %b, expected %b",
                                          got.record_enable, want.record_enable));
            if (got.session_start !== want.session_start)
                report_mismatch($sformatf("session_start %b, expected %b",
                                          got.session_start, want.session_start));
            if (got.session_stop !== want.session_stop)
                report_mismatch($sformatf("session_stop %b, expected %b",
                                          got.session_stop, want.session_stop));
            if (got.generation !== want.generation)
                report_mismatch($sformatf("generation %0d, expected %0d",
                                          got.generation, want.generation));
            if (got.sample_status !== want.sample_status)
                report_mismatch($sformatf("sample_status %b, expected %b",
                                          got.sample_status, want.sample_status));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    algq_smp_if #(.SAMPLE_WIDTH(SMP_W)) smp_ch ();
    algq_res_if                         res_ch ();

    t_gate_scoreboard sb = new();
    int  burst_left = 4;
    int  idle_cycles = 0;
    int  settings_used = 1;
    bit  random_phase = 1'b0;
    bit  held_off = 1'b0;

    activity_log_gate_qualifier_unit #(
        .SAMPLE_WIDTH(SMP_W)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_smp  (smp_ch),
        .o_res  (res_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_sample smp(logic signed [SMP_W-1:0] bus,
                                    logic signed [SMP_W-1:0] cur, logic ovf);
        t_sample s;
        s.bus = bus;
        s.cur = cur;
        s.ovf = ovf;
        return s;
    endfunction

    // A magnitude of 32768 comes out as the most negative value whatever the sign.
    function automatic logic [SMP_W-1:0] signed_of(logic [SMP_W:0] mag);
        logic [SMP_W-1:0] val;
        val = mag[SMP_W-1:0];
        return $urandom_range(0, 1) ? (~val + 1'b1) : val;
    endfunction

    function automatic logic [SMP_W-1:0] pick_above(logic [CFG_W-1:0] thr);
        return signed_of((SMP_W+1)'($urandom_range(thr, 32768)));
    endfunction

    function automatic logic [SMP_W-1:0] pick_below(logic [CFG_W-1:0] thr);
        return signed_of((SMP_W+1)'($urandom_range(0, thr - 1)));
    endfunction

    function automatic t_sample make_noise();
        return smp(SMP_W'($urandom), SMP_W'($urandom), 1'($urandom_range(0, 1)));
    endfunction

    function automatic t_sample make_met();
        if ($urandom_range(0, 3) == 0)
            return smp(SMP_W'($urandom), SMP_W'($urandom), 1'b1);
        return smp(pick_above(sb.thr_bus), pick_above(sb.thr_cur), 1'b0);
    endfunction

    function automatic t_sample make_unmet();
        bit low_bus;
        if (sb.thr_bus == '0 && sb.thr_cur == '0)
            return smp(SMP_W'($urandom), SMP_W'($urandom), 1'b0);
        if (sb.thr_bus == '0)
            low_bus = 1'b0;
        else if (sb.thr_cur == '0)
            low_bus = 1'b1;
        else
            low_bus = 1'($urandom_range(0, 1));
        if (low_bus)
            return smp(pick_below(sb.thr_bus), SMP_W'($urandom), 1'b0);
        return smp(SMP_W'($urandom), pick_below(sb.thr_cur), 1'b0);
    endfunction

    function automatic logic [CFG_W-1:0] pick_threshold();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 16'h8000;
            2:       return CFG_W'($urandom_range(0, 32768));
            default: return CFG_W'($urandom_range(1, 400));
        endcase
    endfunction

    // Offers one sample, waits for its transfer and then either keeps valid high for
    // the next one or opens a gap at the end of a burst.
    task automatic send_sample(input t_sample s);
        smp_ch.valid          <= 1'b1;
        smp_ch.bus_sample     <= s.bus;
        smp_ch.current_sample <= s.cur;
        smp_ch.overflow_flag  <= s.ovf;
        do @(posedge i_clk); while (!smp_ch.ready);
        sb.note_sample(s);
        if (burst_left == 0) begin
            smp_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        smp_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= {16'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_register(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] bus_thr, input logic [CFG_W-1:0] cur_thr,
                             input logic [CFG_W-1:0] hold, input logic [GEN_W-1:0] gen);
        apb_write(REG_BUS_THR, bus_thr);
        apb_write(REG_CUR_THR, cur_thr);
        apb_write(REG_HOLD, hold);
        apb_write(REG_START_GEN, gen);
        settings_used++;
    endtask

    // Mostly runs of samples that all meet, or all miss, the condition, sized around
    // the hold count so that sessions open and close; the rest is unshaped noise.
    task automatic run_random_phase(input int count);
        int      sent;
        int      run_len;
        int      hold_eff;
        bit      met_run;
        t_sample s;
        sent     = 0;
        hold_eff = (sb.hold_cfg == '0) ? 1 : int'(sb.hold_cfg);
        while (sent < count) begin
            if ($urandom_range(0, 4) == 0) begin
                send_sample(make_noise());
                sent++;
            end else begin
                met_run = 1'($urandom_range(0, 1));
                run_len = $urandom_range(1, (hold_eff + 2 > 40) ? 40 : hold_eff + 2);
                repeat (run_len) begin
                    s = met_run ? make_met() : make_unmet();
                    send_sample(s);
                    sent++;
                end
            end
        end
        drain();
    endtask

    initial begin : result_sink
        t_rx_mode     mode;
        int           seg_left;
        logic         rdy;
        t_gate_result got;
        mode     = RX_OPEN;
        seg_left = 20;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                got.record_enable = res_ch.record_enable;
                got.session_start = res_ch.session_start;
                got.session_stop  = res_ch.session_stop;
                got.generation    = res_ch.generation;
                got.sample_status = res_ch.sample_status;
                sb.check_result(got);
            end
            if (seg_left == 0) begin
                if (random_phase && !held_off && sb.results > 300 && smp_ch.valid) begin
                    mode     = RX_HOLD_OFF;
                    seg_left = HOLD_OFF_CYCLES;
                    held_off = 1'b1;
                end else begin
                    mode     = t_rx_mode'($urandom_range(0, 2));
                    seg_left = $urandom_range(8, 48);
                end
            end
            seg_left--;
            case (mode)
                RX_OPEN:   rdy = 1'b1;
                RX_RANDOM: rdy = 1'($urandom_range(0, 1));
                RX_SPARSE: rdy = ($urandom_range(0, 4) == 0);
                default:   rdy = 1'b0;
            endcase
            res_ch.ready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready)
                || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("activity_log_gate_qualifier_unit_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0] hold;
        logic [GEN_W-1:0] gen;
        i_rst_n               <= 1'b0;
        smp_ch.valid          <= 1'b0;
        smp_ch.bus_sample     <= '0;
        smp_ch.current_sample <= '0;
        smp_ch.overflow_flag  <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: zero thresholds pass everything, so a session opens on the
        // second sample with the reset generation.
        send_sample(smp(16'sd0, 16'sd0, 1'b0));
        send_sample(smp(S_MAX, S_MIN, 1'b0));
        send_sample(smp(-16'sd1, 16'sd1, 1'b1));
        drain();

        // Full-scale thresholds: only the most negative reading reaches them. A hold of
        // zero acts as one, and the generation is loaded close to its wrap.
        configure(16'h8000, 16'h8000, 16'd0, 16'hFFFE);
        send_sample(smp(S_MIN, S_MIN, 1'b0));
        send_sample(smp(S_MAX, S_MAX, 1'b0));
        send_sample(smp(S_MIN, S_MAX, 1'b0));
        send_sample(smp(16'sd0, 16'sd0, 1'b1));
        send_sample(smp(S_MIN, 16'sd0, 1'b0));
        send_sample(smp(S_MAX, S_MIN, 1'b1));
        send_sample(smp(-16'sd1, S_MIN, 1'b0));
        drain();

        // Thresholds right at the readings, with a run broken one short of the hold.
        configure(16'd1, 16'd100, 16'd3, 16'hFFFF);
        send_sample(smp(16'sd1, -16'sd100, 1'b0));
        send_sample(smp(-16'sd1, 16'sd100, 1'b0));
        send_sample(smp(16'sd5, -16'sd99, 1'b0));
        repeat (3) send_sample(smp(16'sd1, 16'sd100, 1'b0));
        repeat (3) send_sample(smp(16'sd0, S_MAX, 1'b0));
        send_sample(smp(-16'sd2, S_MIN, 1'b1));
        drain();

        random_phase = 1'b1;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 2)
                hold = 16'hFFFF;
            else if (p == 5)
                hold = CFG_W'($urandom_range(6, 40));
            else
                hold = CFG_W'($urandom_range(0, 5));
            gen = (p == 1) ? 16'hFFFF : GEN_W'($urandom);
            configure(pick_threshold(), pick_threshold(), hold, gen);
            run_random_phase(PHASE_SAMPLES);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run covered %0d samples under %0d register settings, %0d with overflow.",
                 sb.samples, settings_used, sb.overflows);
        $display("Sessions opened %0d, closed %0d, generation wrapped %0d times; %s",
                 sb.opened, sb.closed, sb.wraps,
                 held_off ? "long output hold-off applied." : "long output hold-off not reached.");
        if (sb.errors == 0) begin
            $display("activity_log_gate_qualifier_unit_tb OK");
        end else begin
            $display("activity_log_gate_qualifier_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
